>>> rtl/core/dis_pkg.sv
// Shared constants and types for the device/inode seen set.
`timescale 1ns / 1ps

package dis_pkg;

   localparam int TABLE_ENTRIES_DEF = 256;

   localparam int DEVICE_W   = 32;
   localparam int INODE_W    = 64;
   localparam int KEY_W      = DEVICE_W + INODE_W;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 8;

   // Sequencer states, one-hot.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // Write port of the pair table.
   typedef struct packed {
      logic             en;
      logic [KEY_W-1:0] data;
   } table_wr_type;

endpackage

>>> rtl/core/dis_table_ram.sv
// Pair table storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module dis_table_ram #(
   parameter int DEPTH  = dis_pkg::TABLE_ENTRIES_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  dis_pkg::table_wr_type     wr,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [dis_pkg::KEY_W-1:0] rd_data
);

   logic [dis_pkg::KEY_W-1:0] mem [DEPTH];
   logic [dis_pkg::KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/device_inode_seen_set.sv
// Top level of the device/inode seen set: test-and-insert over a flat pair table.
`timescale 1ns / 1ps

// Each request transfer carries one (device, inode) pair; each response transfer
// says whether that pair was seen since reset (bit 0) and, for a new pair, whether
// the table was full so the pair could not be stored (bit 1). Pairs fill the table
// in arrival order, so a fill count marks the occupied slots and reset empties the
// table at once with no clearing pass. The table memory is read one slot per cycle
// and the search stops at the first match. A new pair is compared against every
// stored pair (at most TABLE_ENTRIES) before it is written; a pair found in slot k
// (counted from 0) ends the search at that slot. While the output register still
// holds an untaken response, the finished verdict waits in the done state until
// the receiver takes it. One request is worked on at a time; a finished response
// may wait in the output register while the next request is accepted and searched.
module device_inode_seen_set #(
   parameter int TABLE_ENTRIES = dis_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata fields, low bit up: device_id[31:0], inode_number[95:32]
   input  logic [dis_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // rsp_tdata fields, low bit up: already_seen[0], table_full[1], zero pad[7:2]
   output logic [dis_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TABLE_ENTRIES);

   dis_pkg::state_type          state_ff, state_in;
   logic [dis_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            rd_idx_ff, rd_idx_in;
   logic                        cmp_vld_ff, cmp_vld_in;
   logic                        hit_ff, hit_in;
   logic                        rsp_vld_ff, rsp_vld_in;
   logic                        seen_ff, seen_in;
   logic                        full_ff, full_in;

   logic                        issue;
   logic                        match;
   logic                        out_free;
   logic [dis_pkg::KEY_W-1:0]   rd_data;
   dis_pkg::table_wr_type       tbl_wr;

   dis_table_ram #(
      .DEPTH  (TABLE_ENTRIES),
      .ADDR_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .wr_addr (count_ff[IDX_W-1:0]),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == dis_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(dis_pkg::RSP_DATA_W - 2){1'b0}}, full_ff, seen_ff};

   // Read the next occupied slot while searching; compare its registered read data.
   assign issue    = (state_ff == dis_pkg::ST_SCAN) && (rd_idx_ff < count_ff);
   assign match    = cmp_vld_ff && (rd_data == key_ff);
   assign out_free = !rsp_vld_ff || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      key_in     = key_ff;
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_vld_in = 1'b0;
      hit_in     = hit_ff;
      rsp_vld_in = rsp_vld_ff;
      seen_in    = seen_ff;
      full_in    = full_ff;
      tbl_wr.en   = 1'b0;
      tbl_wr.data = key_ff;

      // Drop the response once it is taken; a new one may replace it below.
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         dis_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               key_in    = req_tdata[dis_pkg::KEY_W-1:0];
               rd_idx_in = '0;
               hit_in    = 1'b0;
               state_in  = dis_pkg::ST_SCAN;
            end
         end
         dis_pkg::ST_SCAN: begin
            cmp_vld_in = issue;
            if (issue) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            // Stop at the first match, or once every occupied slot is compared.
            if (match) begin
               hit_in     = 1'b1;
               cmp_vld_in = 1'b0;
               state_in   = dis_pkg::ST_DONE;
            end else if (!issue && !cmp_vld_ff) begin
               state_in = dis_pkg::ST_DONE;
            end
         end
         dis_pkg::ST_DONE: begin
            // Hold the verdict until the output register can take it.
            if (out_free) begin
               rsp_vld_in = 1'b1;
               seen_in    = hit_ff;
               full_in    = !hit_ff && (count_ff == CNT_MAX);
               if (!hit_ff && (count_ff != CNT_MAX)) begin
                  tbl_wr.en = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end
               state_in = dis_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dis_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= dis_pkg::ST_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      rd_idx_ff <= rd_idx_in;
      hit_ff    <= hit_in;
      seen_ff   <= seen_in;
      full_ff   <= full_in;
   end

endmodule

>>> sim/tb_device_inode_seen_set.sv
// Self-checking testbench for the device/inode seen set.
`timescale 1ns / 1ps

module tb_device_inode_seen_set;

   localparam int TABLE_ENTRIES   = dis_pkg::TABLE_ENTRIES_DEF;
   localparam int RANDOM_PAIRS    = 1085;
   localparam int HOLD_OFF_CYCLES = 700;
   localparam int LIMIT_CYCLES    = 2000000;

   // Expected answer for one request transfer.
   typedef struct packed {
      logic already_seen;
      logic table_full;
   } answer_type;

   typedef struct {
      logic [dis_pkg::DEVICE_W-1:0] dev;
      logic [dis_pkg::INODE_W-1:0]  ino;
   } pair_type;

   // Scoreboard: keeps its own copy of the pair table, predicts the answer of
   // every accepted request and matches it against responses in order.
   class seen_set_scoreboard;
      logic [dis_pkg::DEVICE_W-1:0] stored_dev [TABLE_ENTRIES];
      logic [dis_pkg::INODE_W-1:0]  stored_ino [TABLE_ENTRIES];
      int unsigned                  fill;
      answer_type                   pending_answers [$];
      int unsigned                  errors;

      function new();
         fill   = 0;
         errors = 0;
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      // Test-and-insert on the local table; queue the answer it gives.
      task note_pair(logic [dis_pkg::DEVICE_W-1:0] dev, logic [dis_pkg::INODE_W-1:0] ino);
         answer_type ans;
         ans = '0;
         for (int k = 0; k < fill; k++) begin
            if (stored_dev[k] == dev && stored_ino[k] == ino) ans.already_seen = 1'b1;
         end
         if (!ans.already_seen) begin
            if (fill < TABLE_ENTRIES) begin
               stored_dev[fill] = dev;
               stored_ino[fill] = ino;
               fill++;
            end else begin
               ans.table_full = 1'b1;
            end
         end
         pending_answers.push_back(ans);
      endtask

      task check_answer(logic [dis_pkg::RSP_DATA_W-1:0] data);
         answer_type want;
         if (pending_answers.size() == 0) begin
            report($sformatf("response %b with no request outstanding", data));
         end else begin
            want = pending_answers.pop_front();
            if (data[0] !== want.already_seen)
               report($sformatf("already_seen %b, expected %b", data[0], want.already_seen));
            if (data[1] !== want.table_full)
               report($sformatf("table_full %b, expected %b", data[1], want.table_full));
            if (data[dis_pkg::RSP_DATA_W-1:2] !== '0)
               report($sformatf("pad bits %b, expected zero",
                                data[dis_pkg::RSP_DATA_W-1:2]));
         end
      endtask

      function int outstanding();
         return pending_answers.size();
      endfunction
   endclass

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   // req_tdata fields, low bit up: device_id[31:0], inode_number[95:32]
   logic [dis_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   // rsp_tdata fields, low bit up: already_seen[0], table_full[1], zero pad[7:2]
   logic [dis_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;

   seen_set_scoreboard sb = new();
   pair_type           sent_pairs [$];
   int unsigned        burst_left  = 0;
   bit                 hold_off_req = 1'b0;
   int unsigned        cycle_count = 0;

   device_inode_seen_set #(.TABLE_ENTRIES(TABLE_ENTRIES)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: a correct run stays far below this even when every search
   // walks the full table.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("[device_inode_seen_set] ERROR");
         $finish;
      end
   end

   // Monitor both channels on the edge where a transfer completes. Check the
   // response first: it always belongs to an older request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_answer(rsp_tdata);
         if (req_tvalid && req_tready)
            sb.note_pair(req_tdata[dis_pkg::DEVICE_W-1:0],
                         req_tdata[dis_pkg::KEY_W-1:dis_pkg::DEVICE_W]);
      end
   end

   // Offer one pair and hold it until transferred. The sender runs in bursts;
   // at the end of a burst drop valid for a random gap. Occasionally pick a
   // long burst so stretches with no idle cycles occur too.
   task automatic offer_pair(input logic [dis_pkg::DEVICE_W-1:0] dev,
                             input logic [dis_pkg::INODE_W-1:0]  ino);
      pair_type p;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
      end
      req_tdata  <= {ino, dev};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      p.dev = dev;
      p.ino = ino;
      sent_pairs.push_back(p);
   endtask

   // Stop offering and wait until every outstanding answer has come back.
   task automatic drain_answers();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Receiver: stall on a 16-bit ready mask, used bit by bit and redrawn once
   // used up, sometimes all ready. On request, hold ready low for a long stretch so
   // the block's output register fills and it stops accepting requests.
   initial begin
      logic [15:0] ready_mask;
      int unsigned slot;
      ready_mask = '1;
      slot       = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            if (slot == 0)
               ready_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            rsp_tready <= ready_mask[slot];
            slot = (slot + 1) % 16;
            @(posedge clock);
         end
      end
   end

   // Stimulus.
   initial begin
      pair_type                     p;
      logic [dis_pkg::DEVICE_W-1:0] dev;
      logic [dis_pkg::INODE_W-1:0]  ino;
      int unsigned                  pick;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, repeats, and pairs that share one half.
      offer_pair(32'h0000_0000, 64'h0);                      // new
      offer_pair(32'h0000_0000, 64'h0);                      // found
      offer_pair(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);    // new
      offer_pair(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);    // found
      offer_pair(32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);    // same inode, other device
      offer_pair(32'hFFFF_FFFF, 64'h0);                      // same device, other inode
      offer_pair(32'h0000_0001, 64'h0);
      offer_pair(32'h0000_0000, 64'h1);
      offer_pair(32'h8000_0000, 64'h8000_0000_0000_0000);
      offer_pair(32'hAAAA_AAAA, 64'h5555_5555_5555_5555);
      offer_pair(32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      offer_pair(32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);    // found
      offer_pair(32'h5555_5555, 64'h5555_5555_5555_5555);    // mixed halves, new
      offer_pair(32'hAAAA_AAAA, 64'h5555_5555_5555_5555);    // found
      offer_pair(32'h0000_0001, 64'h0);                      // found
      drain_answers();

      // Random: fresh pairs fill the table and then hit the full case;
      // repeats of earlier pairs exercise hits and re-rejected pairs;
      // near misses differ from an earlier pair in one field.
      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            p   = sent_pairs[$urandom_range(0, sent_pairs.size() - 1)];
            dev = p.dev;
            ino = p.ino;
         end else if (pick < 55) begin
            p   = sent_pairs[$urandom_range(0, sent_pairs.size() - 1)];
            dev = p.dev;
            ino = p.ino;
            case ($urandom_range(0, 2))
               0: dev = dev ^ (32'd1 << $urandom_range(0, dis_pkg::DEVICE_W - 1));
               1: ino = ino ^ (64'd1 << $urandom_range(0, dis_pkg::INODE_W - 1));
               default: dev = $urandom;
            endcase
         end else if (pick < 62) begin
            dev = $urandom_range(0, 3);
            ino = 64'($urandom_range(0, 7));
         end else begin
            dev = $urandom;
            ino = {$urandom, $urandom};
         end
         offer_pair(dev, ino);

         // Long receiver hold-off while requests keep coming.
         if (i == 300) hold_off_req = 1'b1;
         // Sender pause until everything is answered, once with the table full.
         if (i == 700) drain_answers();
      end
      req_tvalid <= 1'b0;

      // Wait for the last answers, then for one full search more so a stray
      // response would still be caught.
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (TABLE_ENTRIES + 40) @(posedge clock);

      if (sb.errors == 0) begin
         $display("[device_inode_seen_set] OK");
      end else begin
         $display("[device_inode_seen_set] ERROR");
      end
      $finish;
   end

endmodule

>>> device_inode_seen_set.f
rtl/core/dis_pkg.sv
rtl/core/dis_table_ram.sv
rtl/core/device_inode_seen_set.sv
sim/tb_device_inode_seen_set.sv
